FILE: rtl/nrdt_pkg.sv
// Shared types and codes for the note release deadline table.
package nrdt_pkg;

  // Request codes; the fourth code changes nothing and yields only the status item.
  typedef enum logic [1:0] {
    REQ_ADD         = 2'd0,
    REQ_ADVANCE     = 2'd1,
    REQ_RELEASE_ALL = 2'd2,
    REQ_UNUSED      = 2'd3
  } req_type_e;

  // Result item kinds.
  localparam logic ITEM_NOTE_OFF = 1'b0;
  localparam logic ITEM_STATUS   = 1'b1;

  localparam int unsigned TimeW = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [3:0]       channel;
    logic [6:0]       pitch;
    logic [TimeW-1:0] time_value;
  } req_t;

  typedef struct packed {
    logic             item_kind;
    logic [3:0]       off_channel;
    logic [6:0]       off_pitch;
    logic [5:0]       notes_held;
    logic             has_pending;
    logic [TimeW-1:0] earliest_release;
    logic             last_item;
  } result_t;

  typedef struct packed {
    logic [3:0]       chan;
    logic [6:0]       pitch;
    logic [TimeW-1:0] rel_time;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

FILE: rtl/note_release_deadline_table.sv
// Top level of the note release deadline table: sequencer and table memory.
//
// Usage:
//   A request transaction (req_i) is accepted at a rising edge with start_i
//   high and busy_o low. busy_o stays high while the request is worked on.
//   Results appear on result_o for exactly one cycle each, marked by
//   out_valid_o; the receiver cannot hold them off. A request yields zero or
//   more note-off items in table order, then one status item with last_item
//   set.
//   The table lives in one memory, oldest note at address 0. Each request
//   walks the n stored entries once: read entry i, then in the next cycle drop
//   it (emit a note-off) or write it back compacted at the write pointer.
//   Each note-off is registered before it shows; the status item follows
//   the last entry, and busy_o is already low in the cycle it shows.
//   The memory read port walks one entry per cycle.
//   Reset clears the note count; table contents need no clearing since only
//   entries below the count are read.
module note_release_deadline_table
  import nrdt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  req_t    req_i,
  output logic    busy_o,
  output logic    out_valid_o,
  output result_t result_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]   proc_idx_q, proc_idx_d;
  logic              pend_q, pend_d;
  logic [TimeW-1:0]  min_q, min_d;
  logic              has_min_q, has_min_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Memory ports
  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  logic              full;
  logic              rd_more;
  logic              drop;
  logic [CntW-1:0]   fin_count;
  logic [TimeW-1:0]  fin_min;
  logic              fin_has_min;

  nrdt_ram #(
    .Width(EntryW),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign full    = (count_q == CntW'(TABLE_DEPTH));
  assign rd_more = (rd_idx_q < count_q);

  // Decide whether the entry just read is released.
  always_comb begin
    case (req_q.req_type)
      REQ_ADD:         drop = full && (proc_idx_q == '0);
      REQ_ADVANCE:     drop = (ram_rdata.rel_time <= req_q.time_value);
      REQ_RELEASE_ALL: drop = 1'b1;
      default:         drop = 1'b0;
    endcase
  end

  // Closing figures: an add appends the new note after the survivors.
  always_comb begin
    if (req_q.req_type == REQ_ADD) begin
      fin_count   = wr_idx_q + CntW'(1);
      fin_has_min = 1'b1;
      fin_min     = (!has_min_q || (req_q.time_value < min_q)) ? req_q.time_value : min_q;
    end else begin
      fin_count   = wr_idx_q;
      fin_has_min = has_min_q;
      fin_min     = min_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rd_idx_q   <= rd_idx_d;
    wr_idx_q   <= wr_idx_d;
    proc_idx_q <= proc_idx_d;
    min_q      <= min_d;
    has_min_q  <= has_min_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    proc_idx_d  = proc_idx_q;
    pend_d      = 1'b0;
    min_d       = min_q;
    has_min_d   = has_min_q;
    out_d       = out_q;
    out_valid_d = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q[IdxW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = wr_idx_q[IdxW-1:0];
    ram_wdata   = ram_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d     = req_i;
          rd_idx_d  = '0;
          wr_idx_d  = '0;
          has_min_d = 1'b0;
          state_d   = ST_WALK;
        end
      end

      ST_WALK: begin
        // Issue the next read. Write-back addresses always trail the read
        // address, so no entry is read and written in overlapping cycles.
        if (rd_more) begin
          ram_re     = 1'b1;
          rd_idx_d   = rd_idx_q + CntW'(1);
          proc_idx_d = rd_idx_q[IdxW-1:0];
          pend_d     = 1'b1;
        end
        if (pend_q) begin
          if (drop) begin
            out_valid_d          = 1'b1;
            out_d                = '0;
            out_d.item_kind      = ITEM_NOTE_OFF;
            out_d.off_channel    = ram_rdata.chan;
            out_d.off_pitch      = ram_rdata.pitch;
          end else begin
            ram_we   = 1'b1;
            wr_idx_d = wr_idx_q + CntW'(1);
            if (!has_min_q || (ram_rdata.rel_time < min_q)) begin
              min_d = ram_rdata.rel_time;
            end
            has_min_d = 1'b1;
          end
        end
        // Last entry is handled in this cycle; close the request next.
        if (!rd_more) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (req_q.req_type == REQ_ADD) begin
          ram_we          = 1'b1;
          ram_wdata.chan     = req_q.channel;
          ram_wdata.pitch    = req_q.pitch;
          ram_wdata.rel_time = req_q.time_value;
        end
        count_d                = fin_count;
        out_valid_d            = 1'b1;
        out_d                  = '0;
        out_d.item_kind        = ITEM_STATUS;
        out_d.notes_held       = 6'(fin_count);
        out_d.has_pending      = (fin_count != '0);
        out_d.earliest_release = fin_has_min ? fin_min : '0;
        out_d.last_item        = 1'b1;
        state_d                = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

FILE: rtl/nrdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nrdt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nrdt_checker.sv
// Port-level checks for the note release deadline table, with its bind.
module nrdt_checker
  import nrdt_pkg::*;
#(
  parameter int unsigned TableDepth = 32
) (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_o,
  input logic    out_valid_o,
  input result_t result_o
);

  // Accepted transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted request");

  // Only the closing item is a status item.
  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_o.last_item == result_o.item_kind))
    else $error("item kind and last flag disagree");

  // Note-offs come while busy, the status item once the block is free again.
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (busy_o != result_o.last_item))
    else $error("result shown in wrong busy phase");

  // Status figures are consistent with each other.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_o.last_item) |->
      ((result_o.notes_held <= 6'(TableDepth)) &&
       (result_o.has_pending == (result_o.notes_held != '0)) &&
       ((result_o.notes_held != '0) || (result_o.earliest_release == '0))))
    else $error("inconsistent status item");

  // Note-off items carry no status figures.
  a_off_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_o.last_item) |->
      ((result_o.notes_held == '0) && !result_o.has_pending &&
       (result_o.earliest_release == '0)))
    else $error("note-off item carries status fields");

endmodule

bind note_release_deadline_table nrdt_checker #(.TableDepth(TABLE_DEPTH)) u_nrdt_checker (.*);
